[design/histogram_quantile_engine_assert.svh]
// Assertion macros shared by the histogram quantile engine RTL.
`ifndef HISTOGRAM_QUANTILE_ENGINE_ASSERT_SVH
`define HISTOGRAM_QUANTILE_ENGINE_ASSERT_SVH

// Checked on every rising edge, skipped while reset is asserted.
`define HQE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every rising edge, reset included.
`define HQE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

[design/hqe_pkg.sv]
// Constants of the histogram quantile engine: quantile format and register map.
`timescale 1ns / 1ps

package hqe_pkg;

  // Quantile register, unsigned Q0.16 plus one integer bit
  localparam int unsigned QF_BITS      = 17;
  localparam int unsigned QF_FRAC_BITS = 16;
  localparam logic [QF_BITS-1:0] QF_RESET = 17'd32768;

  // Configuration port
  localparam int unsigned APB_ADDR_BITS = 3;
  localparam int unsigned APB_DATA_BITS = 32;

  // Register index, taken from the word address bit
  typedef enum logic {
    REG_QUANTILE = 1'b0,
    REG_NONE     = 1'b1
  } reg_idx_e;

endpackage

[design/hqe_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module hqe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/histogram_quantile_engine.sv]
// Histogram quantile engine top level. Samples of a frame arrive one per
// transaction and are taken at one per cycle while the input is not
// stalled: each bin lives in a single RAM and is updated by a pipelined
// read-modify-write, with a one-entry forward for a sample that hits the
// bin written in the same cycle. The running total, minimum and maximum sit
// in flip-flops. After the sample marked last, the input stalls while the
// last bin update finishes, the threshold is formed (quantile times total),
// the RAM is walked from minimum to maximum, summing bins and zeroing them
// and running past the last bin read to wait for its registered read data,
// and the result register is loaded. That load waits while an earlier
// result is held by the output stall, which stretches the input stall by
// the same amount (the next frame may start while a result waits). After
// reset the RAM is zeroed one bin per cycle over all 2^INTENSITY_BITS bins,
// and no sample is taken during that pass; the quantile register is
// writable at all times.
`timescale 1ns / 1ps
`include "histogram_quantile_engine_assert.svh"

module histogram_quantile_engine #(
  parameter int unsigned INTENSITY_BITS = 12,
  parameter int unsigned COUNT_BITS     = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // sample channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [INTENSITY_BITS-1:0]          sample_value_i,
  input  logic                               frame_last_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [INTENSITY_BITS-1:0]          quantile_intensity_o,
  output logic [INTENSITY_BITS-1:0]          frame_minimum_o,
  output logic [INTENSITY_BITS-1:0]          frame_maximum_o,
  output logic [COUNT_BITS-1:0]              sample_total_o,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [hqe_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  logic [hqe_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [hqe_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                               pready
);

  import hqe_pkg::*;

  localparam int unsigned IB        = INTENSITY_BITS;
  localparam int unsigned CB        = COUNT_BITS;
  localparam int unsigned BINS      = 2 ** IB;
  localparam int unsigned PROD_BITS = QF_FRAC_BITS + CB;

  localparam logic [CB-1:0] CNT_MAX = '1;
  localparam logic [CB-1:0] CNT_ONE = CB'(1);
  localparam logic [IB-1:0] IDX_ONE = IB'(1);

  typedef enum logic [2:0] {
    ST_CLR,
    ST_RUN,
    ST_THR,
    ST_WALK,
    ST_DONE
  } state_e;

  // control registers
  state_e            state_q, state_d;
  logic [IB-1:0]     clr_idx_q, clr_idx_d;
  logic              s1_valid_q, s1_valid_d;
  logic              fwd_valid_q, fwd_valid_d;
  logic              walk_rd_on_q, walk_rd_on_d;
  logic              walk_dv_q, walk_dv_d;
  logic              found_q, found_d;
  logic              out_valid_q, out_valid_d;
  logic [CB-1:0]     total_q, total_d;
  logic [IB-1:0]     min_q, min_d;
  logic [IB-1:0]     max_q, max_d;
  logic [QF_BITS-1:0] quantile_fraction_q, quantile_fraction_d;

  // payload registers
  logic [IB-1:0]     s1_addr_q, s1_addr_d;
  logic              s1_last_q, s1_last_d;
  logic [IB-1:0]     fwd_addr_q, fwd_addr_d;
  logic [CB-1:0]     fwd_data_q, fwd_data_d;
  logic [IB-1:0]     walk_rd_idx_q, walk_rd_idx_d;
  logic [IB-1:0]     walk_data_idx_q, walk_data_idx_d;
  logic [CB-1:0]     acc_q, acc_d;
  logic [CB-1:0]     thr_q, thr_d;
  logic [IB-1:0]     ans_q, ans_d;
  logic [IB-1:0]     res_quant_q, res_quant_d;
  logic [IB-1:0]     res_min_q, res_min_d;
  logic [IB-1:0]     res_max_q, res_max_d;
  logic [CB-1:0]     res_total_q, res_total_d;

  // RAM port
  logic              ram_we;
  logic [IB-1:0]     ram_waddr;
  logic [CB-1:0]     ram_wdata;
  logic              ram_re;
  logic [IB-1:0]     ram_raddr;
  logic [CB-1:0]     ram_rdata;

  // datapath
  logic              in_accept;
  logic              cfg_write;
  logic [CB-1:0]     s1_count_old;
  logic [CB-1:0]     s1_count_new;
  logic [CB:0]       acc_sum;
  logic [CB-1:0]     acc_next;
  logic [PROD_BITS-1:0] thr_prod;
  logic [IB-1:0]     ans_sel;

  hqe_ram #(
    .WIDTH (CB),
    .DEPTH (BINS)
  ) u_bin_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // configuration
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = {{(APB_DATA_BITS-QF_BITS){1'b0}}, quantile_fraction_q};

  always_comb begin
    quantile_fraction_d = quantile_fraction_q;
    if (cfg_write && (reg_idx_e'(paddr[2]) == REG_QUANTILE)) begin
      quantile_fraction_d = pwdata[QF_BITS-1:0];
    end
  end

  assign in_stall_o = (state_q != ST_RUN) || (s1_valid_q && s1_last_q);
  assign in_accept  = in_valid_i && !in_stall_o;

  // bin update, forwarding the value written in the same cycle as the read
  assign s1_count_old = (fwd_valid_q && (fwd_addr_q == s1_addr_q)) ? fwd_data_q : ram_rdata;
  assign s1_count_new = (s1_count_old == CNT_MAX) ? CNT_MAX : s1_count_old + CNT_ONE;

  // saturating walk sum
  assign acc_sum  = {1'b0, acc_q} + {1'b0, ram_rdata};
  assign acc_next = acc_sum[CB] ? CNT_MAX : acc_sum[CB-1:0];

  assign thr_prod = PROD_BITS'(quantile_fraction_q[QF_FRAC_BITS-1:0]) * PROD_BITS'(total_q);

  always_comb begin
    priority if (total_q == '0) begin
      ans_sel = '0;
    end else if (quantile_fraction_q == '0) begin
      ans_sel = min_q;
    end else if (quantile_fraction_q[QF_BITS-1]) begin
      ans_sel = max_q;
    end else if (found_q) begin
      ans_sel = ans_q;
    end else begin
      ans_sel = max_q;
    end
  end

  always_comb begin
    state_d         = state_q;
    clr_idx_d       = clr_idx_q;
    s1_valid_d      = 1'b0;
    fwd_valid_d     = 1'b0;
    walk_rd_on_d    = walk_rd_on_q;
    walk_dv_d       = 1'b0;
    found_d         = found_q;
    out_valid_d     = out_valid_q && out_stall_i;
    total_d         = total_q;
    min_d           = min_q;
    max_d           = max_q;
    s1_addr_d       = s1_addr_q;
    s1_last_d       = s1_last_q;
    fwd_addr_d      = fwd_addr_q;
    fwd_data_d      = fwd_data_q;
    walk_rd_idx_d   = walk_rd_idx_q;
    walk_data_idx_d = walk_data_idx_q;
    acc_d           = acc_q;
    thr_d           = thr_q;
    ans_d           = ans_q;
    res_quant_d     = res_quant_q;
    res_min_d       = res_min_q;
    res_max_d       = res_max_q;
    res_total_d     = res_total_q;
    ram_we          = 1'b0;
    ram_waddr       = '0;
    ram_wdata       = '0;
    ram_re          = 1'b0;
    ram_raddr       = '0;

    unique case (state_q)
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx_q;
        clr_idx_d = clr_idx_q + IDX_ONE;
        if (clr_idx_q == '1) begin
          state_d = ST_RUN;
        end
      end

      ST_RUN: begin
        ram_re     = in_accept;
        ram_raddr  = sample_value_i;
        s1_valid_d = in_accept;
        s1_addr_d  = sample_value_i;
        s1_last_d  = frame_last_i;
        if (in_accept) begin
          total_d = (total_q == CNT_MAX) ? CNT_MAX : total_q + CNT_ONE;
          if (sample_value_i < min_q) begin
            min_d = sample_value_i;
          end
          if (sample_value_i > max_q) begin
            max_d = sample_value_i;
          end
        end
        if (s1_valid_q) begin
          ram_we      = 1'b1;
          ram_waddr   = s1_addr_q;
          ram_wdata   = s1_count_new;
          fwd_valid_d = 1'b1;
          fwd_addr_d  = s1_addr_q;
          fwd_data_d  = s1_count_new;
          if (s1_last_q) begin
            state_d = ST_THR;
          end
        end
      end

      ST_THR: begin
        thr_d         = thr_prod[PROD_BITS-1:QF_FRAC_BITS];
        walk_rd_idx_d = min_q;
        walk_rd_on_d  = 1'b1;
        acc_d         = '0;
        found_d       = 1'b0;
        state_d       = ST_WALK;
      end

      ST_WALK: begin
        // read one bin ahead, sum and zero the bin whose data is back
        ram_re          = walk_rd_on_q;
        ram_raddr       = walk_rd_idx_q;
        walk_dv_d       = walk_rd_on_q;
        walk_data_idx_d = walk_rd_idx_q;
        if (walk_rd_on_q) begin
          if (walk_rd_idx_q == max_q) begin
            walk_rd_on_d = 1'b0;
          end else begin
            walk_rd_idx_d = walk_rd_idx_q + IDX_ONE;
          end
        end
        if (walk_dv_q) begin
          ram_we    = 1'b1;
          ram_waddr = walk_data_idx_q;
          acc_d     = acc_next;
          if (!found_q && (acc_next >= thr_q)) begin
            found_d = 1'b1;
            ans_d   = walk_data_idx_q;
          end
          if (walk_data_idx_q == max_q) begin
            state_d = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        // hold until the result register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          res_quant_d = ans_sel;
          res_min_d   = min_q;
          res_max_d   = max_q;
          res_total_d = total_q;
          total_d     = '0;
          min_d       = '1;
          max_d       = '0;
          state_d     = ST_RUN;
        end
      end

      default: begin
        state_d = ST_CLR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q             <= ST_CLR;
      clr_idx_q           <= '0;
      s1_valid_q          <= 1'b0;
      fwd_valid_q         <= 1'b0;
      walk_rd_on_q        <= 1'b0;
      walk_dv_q           <= 1'b0;
      found_q             <= 1'b0;
      out_valid_q         <= 1'b0;
      total_q             <= '0;
      min_q               <= '1;
      max_q               <= '0;
      quantile_fraction_q <= QF_RESET;
    end else begin
      state_q             <= state_d;
      clr_idx_q           <= clr_idx_d;
      s1_valid_q          <= s1_valid_d;
      fwd_valid_q         <= fwd_valid_d;
      walk_rd_on_q        <= walk_rd_on_d;
      walk_dv_q           <= walk_dv_d;
      found_q             <= found_d;
      out_valid_q         <= out_valid_d;
      total_q             <= total_d;
      min_q               <= min_d;
      max_q               <= max_d;
      quantile_fraction_q <= quantile_fraction_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q       <= s1_addr_d;
    s1_last_q       <= s1_last_d;
    fwd_addr_q      <= fwd_addr_d;
    fwd_data_q      <= fwd_data_d;
    walk_rd_idx_q   <= walk_rd_idx_d;
    walk_data_idx_q <= walk_data_idx_d;
    acc_q           <= acc_d;
    thr_q           <= thr_d;
    ans_q           <= ans_d;
    res_quant_q     <= res_quant_d;
    res_min_q       <= res_min_d;
    res_max_q       <= res_max_d;
    res_total_q     <= res_total_d;
  end

  assign out_valid_o          = out_valid_q;
  assign quantile_intensity_o = res_quant_q;
  assign frame_minimum_o      = res_min_q;
  assign frame_maximum_o      = res_max_q;
  assign sample_total_o       = res_total_q;

  `HQE_ASSERT_ALWAYS(a_minmax_order, (total_q != '0) |-> (min_q <= max_q), "min above max with samples counted")
  `HQE_ASSERT(a_walk_in_range, (state_q == ST_WALK && walk_dv_q) |-> (walk_data_idx_q >= min_q && walk_data_idx_q <= max_q), "walk left the min..max range")
  `HQE_ASSERT(a_last_starts_walk, (s1_valid_q && s1_last_q) |=> (state_q == ST_THR), "last sample did not start the walk")
  `HQE_ASSERT(a_result_from_done, $rose(out_valid_q) |-> $past(state_q == ST_DONE), "result raised outside the load state")

endmodule
